FILE: hw/rtl/rbst_pkg.sv
// Shared constants and code types for the ray against box slab test.
`timescale 1ns / 1ps

package rbst_pkg;

  // Default number format: signed Q16.16
  localparam int unsigned FracBits    = 16;
  localparam int unsigned CoordWidth  = 32;

  localparam int unsigned NumAxes     = 3;
  localparam int unsigned CfgIdxWidth = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5,
    CFG_T_NEAR   = 3'd6,
    CFG_T_FAR    = 3'd7
  } cfg_reg_e;

  // Axis selector, also the index into per-axis register arrays
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

FILE: hw/rtl/rbst_intf.sv
// Valid/ready channel interfaces for box words in and hit words out.
`timescale 1ns / 1ps

interface rbst_box_if #(
  parameter int unsigned CoordWidth = rbst_pkg::CoordWidth
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] box_min_x;
  logic signed [CoordWidth-1:0] box_min_y;
  logic signed [CoordWidth-1:0] box_min_z;
  logic signed [CoordWidth-1:0] box_max_x;
  logic signed [CoordWidth-1:0] box_max_y;
  logic signed [CoordWidth-1:0] box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

FILE: hw/rtl/rbst_recip.sv
// Ray configuration registers and the shared bit-serial reciprocal divider.
`timescale 1ns / 1ps

module rbst_recip #(
  parameter int unsigned FracBits   = rbst_pkg::FracBits,
  parameter int unsigned CoordWidth = rbst_pkg::CoordWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbst_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [CoordWidth-1:0]               cfg_data_i,
  output logic signed [CoordWidth-1:0]        org_o [rbst_pkg::NumAxes],
  output logic signed [CoordWidth-1:0]        inv_o [rbst_pkg::NumAxes],
  output logic signed [CoordWidth-1:0]        t_near_o,
  output logic signed [CoordWidth-1:0]        t_far_o,
  output logic                                busy_o
);

  localparam int unsigned QW   = 2 * FracBits + 1;
  localparam int unsigned CntW = $clog2(QW);
  localparam int unsigned SW   = ((QW > CoordWidth) ? QW : CoordWidth) + 1;
  localparam int unsigned NA   = rbst_pkg::NumAxes;

  localparam logic [CntW-1:0]              LastStep = CntW'(2 * FracBits);
  localparam logic signed [CoordWidth-1:0] MaxV     = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] MinV     = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic signed [CoordWidth-1:0] DirRst   = CoordWidth'(1) << FracBits;
  localparam logic signed [CoordWidth-1:0] InvRst   =
      (FracBits >= CoordWidth - 1) ? MaxV : DirRst;
  localparam logic [SW-1:0]                LimNeg   = SW'(1) << (CoordWidth - 1);

  logic signed [CoordWidth-1:0] org_q [NA];
  logic signed [CoordWidth-1:0] dir_q [NA];
  logic signed [CoordWidth-1:0] inv_q [NA];
  logic signed [CoordWidth-1:0] near_q, far_q;

  logic [NA-1:0]         pend_q, pend_d;
  logic                  busy_q, busy_d;
  rbst_pkg::axis_e       axis_q, axis_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CoordWidth-1:0] rem_q, rem_d;
  logic [QW-1:0]         quo_q, quo_d;
  logic [CoordWidth-1:0] dvs_q, dvs_d;
  logic                  neg_q, neg_d;

  rbst_pkg::cfg_reg_e           cfg_reg;
  logic                         cfg_dir;
  rbst_pkg::axis_e              cfg_axis;
  rbst_pkg::axis_e              pick;
  logic signed [CoordWidth-1:0] dir_sel;
  logic [CoordWidth:0]          r_sh, r_sub;
  logic                         ge;
  logic [QW-1:0]                quo_nx;
  logic [SW-1:0]                q_ext;
  logic signed [CoordWidth-1:0] sat_val;
  logic                         inv_wr, zero_wr;

  assign cfg_reg = rbst_pkg::cfg_reg_e'(cfg_idx_i);

  // Decode direction writes to their axis
  always_comb begin
    cfg_dir  = 1'b0;
    cfg_axis = rbst_pkg::AXIS_X;
    case (cfg_reg)
      rbst_pkg::CFG_DIR_X: begin
        cfg_dir  = 1'b1;
        cfg_axis = rbst_pkg::AXIS_X;
      end
      rbst_pkg::CFG_DIR_Y: begin
        cfg_dir  = 1'b1;
        cfg_axis = rbst_pkg::AXIS_Y;
      end
      rbst_pkg::CFG_DIR_Z: begin
        cfg_dir  = 1'b1;
        cfg_axis = rbst_pkg::AXIS_Z;
      end
      default: begin
        cfg_dir  = 1'b0;
        cfg_axis = rbst_pkg::AXIS_X;
      end
    endcase
  end

  // Pick the lowest pending axis
  always_comb begin
    if (pend_q[rbst_pkg::AXIS_X]) begin
      pick = rbst_pkg::AXIS_X;
    end else if (pend_q[rbst_pkg::AXIS_Y]) begin
      pick = rbst_pkg::AXIS_Y;
    end else begin
      pick = rbst_pkg::AXIS_Z;
    end
  end

  assign dir_sel = dir_q[pick];

  // One restoring step: 2^(2*FracBits) has a single set bit, fed on the first step
  assign r_sh   = {rem_q, (cnt_q == LastStep)};
  assign r_sub  = r_sh - {1'b0, dvs_q};
  assign ge     = (r_sh >= {1'b0, dvs_q});
  assign quo_nx = {quo_q[QW-2:0], ge};

  // Saturate the finished quotient to the signed coordinate range
  assign q_ext = SW'(quo_nx);
  always_comb begin
    if (neg_q) begin
      sat_val = (q_ext > LimNeg) ? MinV : (~q_ext[CoordWidth-1:0]) + 1'b1;
    end else begin
      sat_val = (q_ext >= LimNeg) ? MaxV : q_ext[CoordWidth-1:0];
    end
  end

  // Sequence the divider and track pending direction updates
  always_comb begin
    pend_d  = pend_q;
    busy_d  = busy_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    inv_wr  = 1'b0;
    zero_wr = 1'b0;

    if (busy_q) begin
      rem_d = ge ? r_sub[CoordWidth-1:0] : r_sh[CoordWidth-1:0];
      quo_d = quo_nx;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        inv_wr = 1'b1;
      end
    end else if (|pend_q) begin
      busy_d       = 1'b1;
      axis_d       = pick;
      pend_d[pick] = 1'b0;
      cnt_d        = LastStep;
      rem_d        = '0;
      quo_d        = '0;
      dvs_d        = dir_sel[CoordWidth-1] ? (~dir_sel) + 1'b1 : dir_sel;
      neg_d        = dir_sel[CoordWidth-1];
    end

    // A new direction drops any division running on that axis
    if (cfg_we_i && cfg_dir) begin
      if (busy_d && (axis_d == cfg_axis)) begin
        busy_d = 1'b0;
      end
      if (cfg_data_i == '0) begin
        pend_d[cfg_axis] = 1'b0;
        zero_wr          = 1'b1;
      end else begin
        pend_d[cfg_axis] = 1'b1;
      end
    end
  end

  // Control state of the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      busy_q <= 1'b0;
      axis_q <= rbst_pkg::AXIS_X;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      busy_q <= busy_d;
      axis_q <= axis_d;
      cnt_q  <= cnt_d;
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // Ray registers and reciprocals; a zero direction writes the largest reciprocal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= DirRst;
        inv_q[i] <= InvRst;
      end
      near_q <= '0;
      far_q  <= MaxV;
    end else begin
      for (int i = 0; i < NA; i++) begin
        if (zero_wr && (int'(cfg_axis) == i)) begin
          inv_q[i] <= MaxV;
        end else if (inv_wr && (int'(axis_q) == i)) begin
          inv_q[i] <= sat_val;
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg)
          rbst_pkg::CFG_ORIGIN_X: org_q[rbst_pkg::AXIS_X] <= cfg_data_i;
          rbst_pkg::CFG_ORIGIN_Y: org_q[rbst_pkg::AXIS_Y] <= cfg_data_i;
          rbst_pkg::CFG_ORIGIN_Z: org_q[rbst_pkg::AXIS_Z] <= cfg_data_i;
          rbst_pkg::CFG_DIR_X:    dir_q[rbst_pkg::AXIS_X] <= cfg_data_i;
          rbst_pkg::CFG_DIR_Y:    dir_q[rbst_pkg::AXIS_Y] <= cfg_data_i;
          rbst_pkg::CFG_DIR_Z:    dir_q[rbst_pkg::AXIS_Z] <= cfg_data_i;
          rbst_pkg::CFG_T_NEAR:   near_q <= cfg_data_i;
          rbst_pkg::CFG_T_FAR:    far_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign org_o    = org_q;
  assign inv_o    = inv_q;
  assign t_near_o = near_q;
  assign t_far_o  = far_q;
  assign busy_o   = busy_q || (|pend_q);

endmodule

FILE: hw/rtl/rbst_slab.sv
// One axis of the slab test: entry and exit t of a box along the ray.
`timescale 1ns / 1ps

module rbst_slab #(
  parameter int unsigned FracBits   = rbst_pkg::FracBits,
  parameter int unsigned CoordWidth = rbst_pkg::CoordWidth
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic signed [CoordWidth-1:0] lo_i,
  input  logic signed [CoordWidth-1:0] hi_i,
  input  logic signed [CoordWidth-1:0] org_i,
  input  logic signed [CoordWidth-1:0] inv_i,
  output logic signed [CoordWidth-1:0] t_in_o,
  output logic signed [CoordWidth-1:0] t_out_o
);

  localparam int unsigned PW = 2 * CoordWidth + 1;
  localparam int unsigned MW = PW - FracBits;
  localparam int unsigned SW = ((MW > CoordWidth) ? MW : CoordWidth) + 1;

  localparam logic signed [CoordWidth-1:0] MaxV   = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] MinV   = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic [SW-1:0]                LimNeg = SW'(1) << (CoordWidth - 1);

  // Shift a product magnitude down, then saturate it with its sign
  function automatic logic signed [CoordWidth-1:0] sat_t(input logic [PW-1:0] p,
                                                         input logic neg);
    logic [SW-1:0] m;
    m = SW'(p[PW-1:FracBits]);
    if (neg) begin
      sat_t = (m > LimNeg) ? MinV : (~m[CoordWidth-1:0]) + 1'b1;
    end else begin
      sat_t = (m >= LimNeg) ? MaxV : m[CoordWidth-1:0];
    end
  endfunction

  logic                         inv_neg;
  logic [CoordWidth-1:0]        inv_mag;
  logic signed [CoordWidth-1:0] c_in, c_out;
  logic signed [CoordWidth:0]   d_in, d_out;
  logic [CoordWidth:0]          m_in, m_out;
  logic [PW-1:0]                p_in_d, p_out_d;
  logic [PW-1:0]                p_in_q, p_out_q;
  logic                         n_in_q, n_out_q;

  // Swap the corners when the reciprocal is negative
  assign inv_neg = inv_i[CoordWidth-1];
  assign inv_mag = inv_neg ? (~inv_i) + 1'b1 : inv_i;
  assign c_in    = inv_neg ? hi_i : lo_i;
  assign c_out   = inv_neg ? lo_i : hi_i;

  // Exact differences, one bit wider than a coordinate
  assign d_in  = {c_in[CoordWidth-1], c_in} - {org_i[CoordWidth-1], org_i};
  assign d_out = {c_out[CoordWidth-1], c_out} - {org_i[CoordWidth-1], org_i};
  assign m_in  = d_in[CoordWidth] ? (~d_in) + 1'b1 : d_in;
  assign m_out = d_out[CoordWidth] ? (~d_out) + 1'b1 : d_out;

  assign p_in_d  = PW'(m_in) * PW'(inv_mag);
  assign p_out_d = PW'(m_out) * PW'(inv_mag);

  // Hold product magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_in_q  <= p_in_d;
      p_out_q <= p_out_d;
      n_in_q  <= d_in[CoordWidth] ^ inv_neg;
      n_out_q <= d_out[CoordWidth] ^ inv_neg;
    end
  end

  assign t_in_o  = sat_t(p_in_q, n_in_q);
  assign t_out_o = sat_t(p_out_q, n_out_q);

endmodule

FILE: hw/rtl/ray_box_slab_test_top.sv
// Top level of the ray against axis-aligned box slab test.
`timescale 1ns / 1ps

// Tests one configured ray against a stream of boxes, one box word per clock. Every box
// word gives one hit word after it passes the input register, product register and
// result register; stalls on the hit side back up through the stages only as far as
// they are full. Values are signed fixed point, CoordWidth bits with FracBits fraction
// bits (Q16.16 by default). Writing a nonzero direction component starts the shared
// bit-serial reciprocal divider for that axis; up to three such axes are worked one
// after another, and box words are held off until all are done. A zero direction
// takes effect at once. Write configuration only with no box in flight.
module ray_box_slab_test_top #(
  parameter int unsigned FracBits   = rbst_pkg::FracBits,
  parameter int unsigned CoordWidth = rbst_pkg::CoordWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbst_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CoordWidth-1:0]            cfg_data_i,
  rbst_box_if.sink                         box_i,
  rbst_hit_if.source                       hit_o
);

  localparam int unsigned NA = rbst_pkg::NumAxes;

  logic signed [CoordWidth-1:0] org [NA];
  logic signed [CoordWidth-1:0] inv [NA];
  logic signed [CoordWidth-1:0] t_near, t_far;
  logic                         rc_busy;

  logic signed [CoordWidth-1:0] min_q [NA];
  logic signed [CoordWidth-1:0] max_q [NA];
  logic signed [CoordWidth-1:0] t_in  [NA];
  logic signed [CoordWidth-1:0] t_out [NA];

  logic v1_q, v2_q, v3_q, hit_q;
  logic rdy1, rdy2, rdy3;
  logic accept;

  logic signed [CoordWidth-1:0] tmin, tmax, t_lo, t_hi;
  logic                         hit_c;

  rbst_recip #(
    .FracBits   (FracBits),
    .CoordWidth (CoordWidth)
  ) u_recip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .org_o      (org),
    .inv_o      (inv),
    .t_near_o   (t_near),
    .t_far_o    (t_far),
    .busy_o     (rc_busy)
  );

  // Each stage advances when the next one is empty or advancing
  assign rdy3   = !v3_q || hit_o.ready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = box_i.valid && box_i.ready;

  assign box_i.ready = rdy1 && !rc_busy;

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q[rbst_pkg::AXIS_X] <= box_i.box_min_x;
      min_q[rbst_pkg::AXIS_Y] <= box_i.box_min_y;
      min_q[rbst_pkg::AXIS_Z] <= box_i.box_min_z;
      max_q[rbst_pkg::AXIS_X] <= box_i.box_max_x;
      max_q[rbst_pkg::AXIS_Y] <= box_i.box_max_y;
      max_q[rbst_pkg::AXIS_Z] <= box_i.box_max_z;
    end
  end

  // Per-axis entry and exit t
  for (genvar g = 0; g < NA; g++) begin : g_axis
    rbst_slab #(
      .FracBits   (FracBits),
      .CoordWidth (CoordWidth)
    ) u_slab (
      .clk_i   (clk_i),
      .load_i  (rdy2 && v1_q),
      .lo_i    (min_q[g]),
      .hi_i    (max_q[g]),
      .org_i   (org[g]),
      .inv_i   (inv[g]),
      .t_in_o  (t_in[g]),
      .t_out_o (t_out[g])
    );
  end

  // Combine the slabs and check against the t limits
  always_comb begin
    tmin = t_in[rbst_pkg::AXIS_X];
    if (t_in[rbst_pkg::AXIS_Y] > tmin) tmin = t_in[rbst_pkg::AXIS_Y];
    if (t_in[rbst_pkg::AXIS_Z] > tmin) tmin = t_in[rbst_pkg::AXIS_Z];
    tmax = t_out[rbst_pkg::AXIS_X];
    if (t_out[rbst_pkg::AXIS_Y] < tmax) tmax = t_out[rbst_pkg::AXIS_Y];
    if (t_out[rbst_pkg::AXIS_Z] < tmax) tmax = t_out[rbst_pkg::AXIS_Z];
    t_lo  = (t_near > tmin) ? t_near : tmin;
    t_hi  = (t_far < tmax) ? t_far : tmax;
    hit_c = (tmax >= tmin) && (t_hi >= t_lo);
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      hit_q <= hit_c;
    end
  end

  assign hit_o.valid = v3_q;
  assign hit_o.hit   = hit_q;

  // An item in the input register that may advance reaches the product stage
  a_s1_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("box word lost between input and product stages");

  // A product that may advance becomes a visible result
  a_s2_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> hit_o.valid)
    else $error("product word lost before the result register");

  // A nonzero direction write holds off box words while its reciprocal is worked out
  a_dir_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_data_i != '0 &&
     (cfg_idx_i == rbst_pkg::CFG_DIR_X || cfg_idx_i == rbst_pkg::CFG_DIR_Y ||
      cfg_idx_i == rbst_pkg::CFG_DIR_Z)) |=> !box_i.ready)
    else $error("box word taken while a reciprocal is pending");

endmodule
